>>> sv/ordered_list_append_delete_unit_assert.svh
// ----------------------------------------------------------------------------
// ordered_list_append_delete_unit_assert.svh
// Assertion macros shared by the ordered list unit.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_APPEND_DELETE_UNIT_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define OLAD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// Next-cycle implication, disabled while reset is asserted
`define OLAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

>>> sv/olad_pkg.sv
// ----------------------------------------------------------------------------
// olad_pkg
// Types, codes and defaults shared by the ordered list unit.
// ----------------------------------------------------------------------------
package olad_pkg;

    // Default number of list cells
    localparam int CAPACITY_DEF = 16;
    // Most readout results given for one readout command
    localparam int OUT_MAX = 16;

    // Command codes
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    // Unit control states
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_READ = 1'b1
    } fsm_t;

endpackage

>>> sv/olad_cmd_if.sv
// ----------------------------------------------------------------------------
// olad_cmd_if
// Command channel: valid/ready handshake carrying cmd and value.
// ----------------------------------------------------------------------------
interface olad_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

>>> sv/olad_res_if.sv
// ----------------------------------------------------------------------------
// olad_res_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface olad_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [31:0] entry_value;
    logic               last;

    modport source (output valid, output status, output entry_count,
                    output entry_value, output last, input ready);
    modport sink   (input valid, input status, input entry_count,
                    input entry_value, input last, output ready);
endinterface

>>> sv/olad_cell.sv
// ----------------------------------------------------------------------------
// olad_cell
// One list cell: holds one entry, compares it with the delete key and
// takes a new entry from the key, its upper neighbour or the head.
// ----------------------------------------------------------------------------
module olad_cell
    import olad_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX      = 0,
    localparam int CW      = $clog2(CAPACITY + 1)
)
(
    input  logic               clk,
    input  cell_op_t           op,
    input  logic signed [31:0] key,
    input  logic [CW-1:0]      count,
    input  logic signed [31:0] nbr_value,
    input  logic signed [31:0] head_value,
    input  logic               hit_in,
    output logic               hit_out,
    output logic signed [31:0] value
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               occupied;
    logic               is_tail_slot;
    logic               is_last_entry;

    assign occupied      = CW'(IDX) < count;
    assign is_tail_slot  = CW'(IDX) == count;
    assign is_last_entry = CW'(IDX) == count - CW'(1);

    // Pass the first-match flag on: this cell and all above it close the gap
    assign hit_out = hit_in || (occupied && (value_reg == key));

    // Select the new entry
    always_comb
    begin
        value_next = value_reg;
        case (op)
            CELL_APPEND:
            begin
                if (is_tail_slot)
                    value_next = key;
            end
            CELL_DELETE:
            begin
                if (hit_out)
                    value_next = nbr_value;
            end
            CELL_ROTATE:
            begin
                if (is_last_entry)
                    value_next = head_value;
                else if (occupied)
                    value_next = nbr_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> sv/ordered_list_append_delete_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_append_delete_unit
// Ordered list of signed 32-bit entries, oldest first, kept in a ring of
// cells. Append at the tail, delete the first match, read out in order.
//
//   channel | dir | payload                                   | transfer
//   req     | in  | cmd, value                                | valid & ready
//   rsp     | out | status, entry_count, entry_value, last    | valid & ready
//
// Append, delete and unused codes each give one result. In a readout the
// occupied cells rotate one place a cycle, unless a given entry waits for
// a full result register; the head cell feeds the result register, so the
// ring is back in order when the readout ends. At most OUT_MAX entries are given.
// Reset clears the count and the control state; cell contents need none.
// req is not ready during a readout or while a result waits untaken.
// ----------------------------------------------------------------------------
`include "ordered_list_append_delete_unit_assert.svh"

module ordered_list_append_delete_unit
    import olad_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    olad_cmd_if.sink   req,
    olad_res_if.source rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    fsm_t               state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [4:0]         out_count_reg, out_count_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    cell_op_t           cell_op;
    logic signed [31:0] cell_value [CAPACITY];
    logic [CAPACITY:0]  hit_chain;
    logic               found;

    logic               out_space;
    logic               req_fire;
    logic               rd_emit;
    logic               rd_adv;
    logic               rd_done;
    logic               rd_last_emit;

    // Handshake and readout progress
    assign out_space    = !out_valid_reg || rsp.ready;
    assign req.ready    = (state_reg == FSM_IDLE) && out_space;
    assign req_fire     = req.valid && req.ready;
    assign rd_emit      = int'(rd_idx_reg) < OUT_MAX;
    assign rd_adv       = (state_reg == FSM_READ) && (!rd_emit || out_space);
    assign rd_done      = rd_idx_reg == count_reg - CW'(1);
    assign rd_last_emit = (int'(rd_idx_reg) + 1) ==
                          ((int'(count_reg) < OUT_MAX) ? int'(count_reg) : OUT_MAX);

    // Ring of cells with a first-match chain from the head
    assign hit_chain[0] = 1'b0;
    assign found        = hit_chain[CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        olad_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .key        (req.value),
            .count      (count_reg),
            .nbr_value  (cell_value[(i + 1) % CAPACITY]),
            .head_value (cell_value[0]),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i + 1]),
            .value      (cell_value[i])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (req_fire && (req.cmd == CMD_READ) && (count_reg != '0))
                    state_next = FSM_READ;
            end
            FSM_READ:
            begin
                if (rd_adv && rd_done)
                    state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Cell control, count, readout index and result register
    always_comb
    begin
        cell_op         = CELL_HOLD;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (req_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_DONE;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                    rd_idx_next     = '0;
                    unique case (req.cmd)
                        CMD_APPEND:
                        begin
                            if (count_reg == CW'(CAPACITY))
                                out_status_next = ST_FULL;
                            else
                            begin
                                cell_op    = CELL_APPEND;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_DELETE:
                        begin
                            cell_op = CELL_DELETE;
                            if (found)
                                count_next = count_reg - CW'(1);
                            else
                                out_status_next = ST_NOT_FOUND;
                        end
                        CMD_READ:
                        begin
                            if (count_reg == '0)
                                out_status_next = ST_EMPTY;
                            else
                                out_valid_next = out_valid_reg && !rsp.ready;
                        end
                        default:
                        begin
                            out_status_next = ST_DONE;
                        end
                    endcase
                    out_count_next = 5'(count_next);
                end
            end
            FSM_READ:
            begin
                if (rd_adv)
                begin
                    cell_op     = CELL_ROTATE;
                    rd_idx_next = rd_done ? '0 : rd_idx_reg + CW'(1);
                    if (rd_emit)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_DONE;
                        out_count_next  = 5'(count_reg);
                        out_value_next  = cell_value[0];
                        out_last_next   = rd_last_emit;
                    end
                end
            end
            default:
            begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.entry_value = out_value_reg;
    assign rsp.last        = out_last_reg;

    `OLAD_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, int'(count_reg) <= CAPACITY)
    `OLAD_ASSERT_IMPL(a_no_req_in_read, clk, rst_n, state_reg == FSM_READ, !req.ready)
    `OLAD_ASSERT_NEXT(a_append_grows, clk, rst_n, req_fire && (req.cmd == CMD_APPEND) && (int'(count_reg) < CAPACITY), count_reg == $past(count_reg) + CW'(1))
    `OLAD_ASSERT_NEXT(a_read_ends, clk, rst_n, rd_adv && rd_done, (state_reg == FSM_IDLE) && (rd_idx_reg == '0))
    `OLAD_ASSERT_NEXT(a_read_keeps_count, clk, rst_n, state_reg == FSM_READ, count_reg == $past(count_reg))

endmodule
